// ----- hdl/gbk_pkg.sv -----
`timescale 1ns / 1ps

package gbk_pkg;

	localparam int TABLE_DEPTH_DEF = 32768;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic [7:0] SINGLE_MAX = 8'h80;
	localparam logic [7:0] LEAD_MIN = 8'h81;
	localparam logic [7:0] LEAD_MAX = 8'hFE;
	localparam logic [7:0] TRAIL_MIN = 8'h40;
	localparam logic [7:0] TRAIL_MAX = 8'hFE;
	localparam logic [7:0] TRAIL_GAP = 8'h7F;
	localparam logic [14:0] ROW_SPAN = 15'd191;

	typedef enum logic [1:0] {
		FUNC_DECODE = 2'd0,
		FUNC_WRITE  = 2'd1,
		FUNC_END    = 2'd2
	} func_t;

	typedef enum logic [1:0] {
		QOP_WRITE   = 2'd0,
		QOP_LOOKUP  = 2'd1,
		QOP_LITERAL = 2'd2
	} qop_t;

	typedef struct packed {
		logic [1:0]  func;
		logic [7:0]  byte_in;
		logic [14:0] table_addr;
		logic [15:0] table_word;
	} in_word_t;

	typedef struct packed {
		logic [15:0] code_unit;
		logic        last;
	} out_word_t;

	typedef struct packed {
		qop_t        op;
		logic [14:0] addr;
		logic [15:0] data;
		logic        last;
	} queue_entry_t;

	typedef struct packed {
		logic       lead_pending;
		logic [7:0] lead_byte;
	} front_status_t;

endpackage

// ----- hdl/gbk_front.sv -----
`timescale 1ns / 1ps

module gbk_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  gbk_pkg::in_word_t      in_word,
	output logic                   push_valid,
	input  logic                   push_ready,
	output gbk_pkg::queue_entry_t  push_entry,
	output gbk_pkg::front_status_t status
);

	logic                  lead_pending_q;
	logic [7:0]            lead_byte_q;
	logic                  accept;
	logic                  emit;
	logic                  is_trail;
	logic [6:0]            lead_off;
	logic [14:0]           lookup_idx;
	logic                  pending_d;
	logic [7:0]            lead_d;
	gbk_pkg::queue_entry_t entry;

	assign in_ready = push_ready;
	assign accept   = in_valid && in_ready;

	assign is_trail = (in_word.byte_in >= gbk_pkg::TRAIL_MIN) &&
			(in_word.byte_in <= gbk_pkg::TRAIL_MAX) &&
			(in_word.byte_in != gbk_pkg::TRAIL_GAP);
	assign lead_off   = 7'(lead_byte_q - gbk_pkg::LEAD_MIN);
	assign lookup_idx = 15'(15'(lead_off) * gbk_pkg::ROW_SPAN) +
			15'(8'(in_word.byte_in - gbk_pkg::TRAIL_MIN));

	always_comb begin
		emit       = 1'b0;
		pending_d  = lead_pending_q;
		lead_d     = lead_byte_q;
		entry.op   = gbk_pkg::QOP_LITERAL;
		entry.addr = in_word.table_addr;
		entry.data = in_word.table_word;
		entry.last = 1'b0;
		unique case (in_word.func)
			gbk_pkg::FUNC_WRITE: begin
				emit     = 1'b1;
				entry.op = gbk_pkg::QOP_WRITE;
			end
			gbk_pkg::FUNC_END: begin
				emit       = 1'b1;
				pending_d  = 1'b0;
				lead_d     = 8'h00;
				entry.data = 16'h0000;
				entry.last = 1'b1;
			end
			gbk_pkg::FUNC_DECODE: begin
				pending_d = 1'b0;
				lead_d    = 8'h00;
				if (lead_pending_q && is_trail) begin
					emit       = 1'b1;
					entry.op   = gbk_pkg::QOP_LOOKUP;
					entry.addr = lookup_idx;
				end else if (in_word.byte_in <= gbk_pkg::SINGLE_MAX) begin
					emit       = 1'b1;
					entry.data = {8'h00, in_word.byte_in};
				end else if (in_word.byte_in <= gbk_pkg::LEAD_MAX) begin
					pending_d = 1'b1;
					lead_d    = in_word.byte_in;
				end
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lead_pending_q <= 1'b0;
			lead_byte_q    <= 8'h00;
		end else if (accept) begin
			lead_pending_q <= pending_d;
			lead_byte_q    <= lead_d;
		end
	end

	assign push_valid          = accept && emit;
	assign push_entry          = entry;
	assign status.lead_pending = lead_pending_q;
	assign status.lead_byte    = lead_byte_q;

endmodule

// ----- hdl/gbk_queue.sv -----
`timescale 1ns / 1ps

module gbk_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push_valid,
	output logic                  push_ready,
	input  gbk_pkg::queue_entry_t push_entry,
	output logic                  pop_valid,
	input  logic                  pop_ready,
	output gbk_pkg::queue_entry_t pop_entry
);

	gbk_pkg::queue_entry_t             slot_q [gbk_pkg::QUEUE_DEPTH];
	logic [gbk_pkg::QPTR_W-1:0]        wr_ptr_q;
	logic [gbk_pkg::QPTR_W-1:0]        rd_ptr_q;
	logic [gbk_pkg::QCNT_W-1:0]        count_q;
	logic                              do_push;
	logic                              do_pop;

	assign push_ready = count_q != gbk_pkg::QCNT_W'(gbk_pkg::QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign pop_entry  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- hdl/gbk_back.sv -----
`timescale 1ns / 1ps

module gbk_back #(
	parameter int TABLE_DEPTH = gbk_pkg::TABLE_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  pop_valid,
	output logic                  pop_ready,
	input  gbk_pkg::queue_entry_t pop_entry,
	output logic                  out_valid,
	input  logic                  out_ready,
	output gbk_pkg::out_word_t    out_word
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam logic [15:0] DEPTH16 = 16'(TABLE_DEPTH);

	logic [15:0]        table_mem [TABLE_DEPTH];
	logic [15:0]        rdata_q;
	logic               valid_s1;
	logic               lookup_s1;
	logic [15:0]        data_s1;
	logic               last_s1;
	logic               out_valid_q;
	gbk_pkg::out_word_t out_q;
	logic               pop;
	logic               adv_s1;
	logic               wr_en;
	logic               rd_en;

	assign adv_s1    = valid_s1 && (!out_valid_q || out_ready);
	assign pop_ready = !valid_s1 || adv_s1;
	assign pop       = pop_valid && pop_ready;
	assign wr_en     = pop && (pop_entry.op == gbk_pkg::QOP_WRITE) &&
			({1'b0, pop_entry.addr} < DEPTH16);
	assign rd_en     = pop && (pop_entry.op == gbk_pkg::QOP_LOOKUP);

	// code table, one write or one registered read per cycle when an entry is popped
	always_ff @(posedge clk) begin
		if (wr_en) begin
			table_mem[pop_entry.addr[AW-1:0]] <= pop_entry.data;
		end
		if (rd_en) begin
			rdata_q <= table_mem[pop_entry.addr[AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			lookup_s1 <= pop_entry.op == gbk_pkg::QOP_LOOKUP;
			data_s1   <= pop_entry.data;
			last_s1   <= pop_entry.last;
		end
		if (adv_s1) begin
			out_q.code_unit <= lookup_s1 ? rdata_q : data_s1;
			out_q.last      <= last_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop_ready) begin
				valid_s1 <= pop && (pop_entry.op != gbk_pkg::QOP_WRITE);
			end
			if (adv_s1) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_q;

endmodule

// ----- hdl/gbk_to_unicode_decoder.sv -----
`timescale 1ns / 1ps

// gbk to 16-bit unicode decoder. takes one input word per cycle, sustained, as long as the
// output side keeps taking results; a word that causes a result passes through the front
// classification and queue, the code table read and the output register. the rate is set
// by the single port pair of the code table: one table write or one table read per cycle,
// and each table-write word takes one such slot. the table has no reset and must be loaded
// with table-write words before any double-byte character is decoded; a four-entry queue
// between the front and the table side absorbs stalls.
module gbk_to_unicode_decoder #(
	parameter int TABLE_DEPTH = gbk_pkg::TABLE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  gbk_pkg::in_word_t  in_word,
	output logic               out_valid,
	input  logic               out_ready,
	output gbk_pkg::out_word_t out_word
);

	logic                   push_valid;
	logic                   push_ready;
	gbk_pkg::queue_entry_t  push_entry;
	logic                   pop_valid;
	logic                   pop_ready;
	gbk_pkg::queue_entry_t  pop_entry;
	gbk_pkg::front_status_t front_status;

	gbk_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_word    (in_word),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry),
		.status     (front_status)
	);

	gbk_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_entry  (pop_entry)
	);

	gbk_back #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_entry (pop_entry),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word  (out_word)
	);

`ifndef ASSERT_OFF
	// a full queue always has something to hand on
	a_full_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> pop_valid)
		else $error("input stalled with empty queue");

	// terminator carries a zero code unit
	a_last_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_word.last) |-> (out_word.code_unit == 16'h0000))
		else $error("terminator with non-zero code unit");

	// end of string drops any held lead
	a_end_clears_lead: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && in_word.func == gbk_pkg::FUNC_END)
		|=> !front_status.lead_pending)
		else $error("lead still held after end of string");

	// a held lead byte is always in the lead range
	a_lead_range: assert property (@(posedge clk) disable iff (!arst_n)
		front_status.lead_pending |-> (front_status.lead_byte >= gbk_pkg::LEAD_MIN &&
		front_status.lead_byte <= gbk_pkg::LEAD_MAX))
		else $error("held lead byte out of range");
`endif

endmodule

// ----- tb/gbk_to_unicode_decoder_tb.sv -----
`timescale 1ns / 1ps

module gbk_to_unicode_decoder_tb;

	localparam logic [1:0] FUNC_UNUSED = 2'd3;
	localparam int RANDOM_WORDS = 1250;
	localparam int STALL_MAX = 16;
	localparam int HOLD_AFTER = 200;
	localparam int HOLD_CYCLES = 300;
	localparam int IDLE_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 10;
	localparam int LAST_INDEX = 24065;

	typedef struct packed {
		logic [1:0]  func;
		logic [7:0]  byte_in;
		logic [14:0] table_addr;
		logic [15:0] table_word;
		logic        typed;
		logic        gives;
		logic [15:0] code_unit;
		logic        last;
	} stim_row_t;

	// typed rows carry their own result, the rest go through the predictor
	localparam stim_row_t DIRECTED [25] = '{
		'{gbk_pkg::FUNC_DECODE, 8'h00, 15'd0,     16'h0000, 1'b1, 1'b1, 16'h0000, 1'b0},
		'{gbk_pkg::FUNC_DECODE, 8'h80, 15'd0,     16'h0000, 1'b1, 1'b1, 16'h0080, 1'b0},
		'{gbk_pkg::FUNC_WRITE,  8'h00, 15'd0,     16'hFFFF, 1'b1, 1'b0, 16'h0000, 1'b0},
		'{gbk_pkg::FUNC_WRITE,  8'h00, 15'd24065, 16'h8001, 1'b1, 1'b0, 16'h0000, 1'b0},
		'{gbk_pkg::FUNC_DECODE, 8'h81, 15'd0,     16'h0000, 1'b1, 1'b0, 16'h0000, 1'b0},
		'{gbk_pkg::FUNC_DECODE, 8'h40, 15'd0,     16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0},
		'{gbk_pkg::FUNC_DECODE, 8'hFE, 15'd0,     16'h0000, 1'b1, 1'b0, 16'h0000, 1'b0},
		'{gbk_pkg::FUNC_DECODE, 8'hFE, 15'd0,     16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0},
		'{gbk_pkg::FUNC_DECODE, 8'h81, 15'd0,     16'h0000, 1'b1, 1'b0, 16'h0000, 1'b0},
		'{gbk_pkg::FUNC_DECODE, 8'h7F, 15'd0,     16'h0000, 1'b1, 1'b1, 16'h007F, 1'b0},
		'{gbk_pkg::FUNC_DECODE, 8'h90, 15'd0,     16'h0000, 1'b1, 1'b0, 16'h0000, 1'b0},
		'{gbk_pkg::FUNC_DECODE, 8'h3F, 15'd0,     16'h0000, 1'b1, 1'b1, 16'h003F, 1'b0},
		'{gbk_pkg::FUNC_DECODE, 8'hA0, 15'd0,     16'h0000, 1'b1, 1'b0, 16'h0000, 1'b0},
		'{gbk_pkg::FUNC_DECODE, 8'hFF, 15'd0,     16'h0000, 1'b1, 1'b0, 16'h0000, 1'b0},
		'{gbk_pkg::FUNC_DECODE, 8'hFF, 15'd0,     16'h0000, 1'b1, 1'b0, 16'h0000, 1'b0},
		'{gbk_pkg::FUNC_DECODE, 8'hB0, 15'd0,     16'h0000, 1'b1, 1'b0, 16'h0000, 1'b0},
		'{gbk_pkg::FUNC_END,    8'h00, 15'd0,     16'h0000, 1'b1, 1'b1, 16'h0000, 1'b1},
		'{gbk_pkg::FUNC_DECODE, 8'h40, 15'd0,     16'h0000, 1'b1, 1'b1, 16'h0040, 1'b0},
		'{gbk_pkg::FUNC_DECODE, 8'hD0, 15'd0,     16'h0000, 1'b1, 1'b0, 16'h0000, 1'b0},
		'{gbk_pkg::FUNC_WRITE,  8'h00, 15'd15105, 16'h5A5A, 1'b1, 1'b0, 16'h0000, 1'b0},
		'{gbk_pkg::FUNC_DECODE, 8'h50, 15'd0,     16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0},
		'{gbk_pkg::FUNC_DECODE, 8'h81, 15'd0,     16'h0000, 1'b1, 1'b0, 16'h0000, 1'b0},
		'{FUNC_UNUSED,          8'h00, 15'd0,     16'h0000, 1'b1, 1'b0, 16'h0000, 1'b0},
		'{gbk_pkg::FUNC_DECODE, 8'h40, 15'd0,     16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0},
		'{gbk_pkg::FUNC_END,    8'h00, 15'd0,     16'h0000, 1'b1, 1'b1, 16'h0000, 1'b1}
	};

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	gbk_pkg::in_word_t  in_word = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	gbk_pkg::out_word_t out_word;

	bit                 lead_held;
	logic [7:0]         held_lead;
	logic [15:0]        unit_map [gbk_pkg::TABLE_DEPTH_DEF];
	bit                 unit_loaded [gbk_pkg::TABLE_DEPTH_DEF];
	gbk_pkg::out_word_t due_units [$];
	int                 errors;
	int                 words_taken;
	int                 results_seen;
	bit                 tx_calm;
	bit                 rx_calm;

	gbk_to_unicode_decoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word  (out_word)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic bit trail_ok(input logic [7:0] b);
		return b >= gbk_pkg::TRAIL_MIN && b <= gbk_pkg::TRAIL_MAX && b != gbk_pkg::TRAIL_GAP;
	endfunction

	function automatic int pair_index(input logic [7:0] lead, input logic [7:0] trail);
		return (int'(lead) - int'(gbk_pkg::LEAD_MIN)) * int'(gbk_pkg::ROW_SPAN) +
			(int'(trail) - int'(gbk_pkg::TRAIL_MIN));
	endfunction

	function automatic void decode_step(input gbk_pkg::in_word_t w, output bit gives,
			output gbk_pkg::out_word_t unit);
		bit paired;
		paired = 1'b0;
		gives = 1'b0;
		unit = '0;
		case (w.func)
		gbk_pkg::FUNC_WRITE: begin
			unit_map[w.table_addr] = w.table_word;
			unit_loaded[w.table_addr] = 1'b1;
		end
		gbk_pkg::FUNC_END: begin
			lead_held = 1'b0;
			held_lead = '0;
			gives = 1'b1;
			unit.last = 1'b1;
		end
		gbk_pkg::FUNC_DECODE: begin
			if (lead_held) begin
				lead_held = 1'b0;
				if (trail_ok(w.byte_in)) begin
					unit.code_unit = unit_map[pair_index(held_lead, w.byte_in)];
					gives = 1'b1;
					paired = 1'b1;
				end
				held_lead = '0;
			end
			if (!paired) begin
				if (w.byte_in <= gbk_pkg::SINGLE_MAX) begin
					gives = 1'b1;
					unit.code_unit = {8'h00, w.byte_in};
				end else if (w.byte_in >= gbk_pkg::LEAD_MIN &&
						w.byte_in <= gbk_pkg::LEAD_MAX) begin
					lead_held = 1'b1;
					held_lead = w.byte_in;
				end
			end
		end
		default: ;
		endcase
	endfunction

	task automatic send_word(input gbk_pkg::in_word_t w, input bit typed,
			input bit typed_gives, input gbk_pkg::out_word_t typed_unit);
		int gap;
		bit gives;
		gbk_pkg::out_word_t unit;
		if ($urandom_range(0, 31) == 0)
			tx_calm = !tx_calm;
		gap = tx_calm ? 0 : $urandom_range(0, STALL_MAX);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_word <= w;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		decode_step(w, gives, unit);
		if (typed) begin
			gives = typed_gives;
			unit = typed_unit;
		end
		if (gives)
			due_units.push_back(unit);
		if (w.func != FUNC_UNUSED)
			words_taken++;
	endtask

	function automatic gbk_pkg::in_word_t noise_word(input logic [1:0] func);
		logic [63:0] bits;
		gbk_pkg::in_word_t w;
		bits = {$urandom, $urandom};
		w = bits[$bits(gbk_pkg::in_word_t)-1:0];
		w.func = func;
		return w;
	endfunction

	// loads the table entry first where the byte would complete an unloaded pair
	task automatic send_byte(input logic [7:0] b);
		gbk_pkg::in_word_t w;
		if (lead_held && trail_ok(b) && !unit_loaded[pair_index(held_lead, b)]) begin
			w = noise_word(gbk_pkg::FUNC_WRITE);
			w.table_addr = 15'(pair_index(held_lead, b));
			send_word(w, 1'b0, 1'b0, '0);
		end
		w = noise_word(gbk_pkg::FUNC_DECODE);
		w.byte_in = b;
		send_word(w, 1'b0, 1'b0, '0);
	endtask

	initial begin : word_source
		gbk_pkg::in_word_t w;
		gbk_pkg::out_word_t typed_unit;
		int pick;
		logic [7:0] trail;
		bit drained_once;
		drained_once = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED[i]) begin
			w = '0;
			w.func = DIRECTED[i].func;
			w.byte_in = DIRECTED[i].byte_in;
			w.table_addr = DIRECTED[i].table_addr;
			w.table_word = DIRECTED[i].table_word;
			typed_unit.code_unit = DIRECTED[i].code_unit;
			typed_unit.last = DIRECTED[i].last;
			send_word(w, DIRECTED[i].typed, DIRECTED[i].gives, typed_unit);
		end

		words_taken = 0;
		while (words_taken < RANDOM_WORDS) begin
			if (!drained_once && words_taken >= RANDOM_WORDS / 2) begin
				drained_once = 1'b1;
				in_valid <= 1'b0;
				@(posedge clk);
				while (due_units.size() != 0) @(posedge clk);
			end
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				send_byte(8'($urandom_range(gbk_pkg::LEAD_MIN, gbk_pkg::LEAD_MAX)));
				trail = 8'($urandom_range(gbk_pkg::TRAIL_MIN, gbk_pkg::TRAIL_MAX));
				if (trail == gbk_pkg::TRAIL_GAP)
					trail = gbk_pkg::TRAIL_MAX;
				send_byte(trail);
			end else if (pick < 70) begin
				send_byte(8'($urandom_range(0, gbk_pkg::SINGLE_MAX)));
			end else if (pick < 77) begin
				send_word(noise_word(gbk_pkg::FUNC_END), 1'b0, 1'b0, '0);
			end else if (pick < 85) begin
				w = noise_word(gbk_pkg::FUNC_WRITE);
				w.table_addr = 15'($urandom_range(0, LAST_INDEX));
				send_word(w, 1'b0, 1'b0, '0);
			end else if (pick < 96) begin
				// broken pairs: a lead, on about half the picks, followed by any byte at all
				if ($urandom_range(0, 1) == 1)
					send_byte(8'($urandom_range(gbk_pkg::LEAD_MIN, gbk_pkg::LEAD_MAX)));
				send_byte(8'($urandom_range(0, 255)));
			end else begin
				send_word(noise_word(FUNC_UNUSED), 1'b0, 1'b0, '0);
			end
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (due_units.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin : result_sink
		int stall;
		bit held_off;
		gbk_pkg::out_word_t want;
		held_off = 1'b0;
		@(posedge arst_n);
		forever begin
			if (!held_off && results_seen >= HOLD_AFTER) begin
				held_off = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				if ($urandom_range(0, 31) == 0)
					rx_calm = !rx_calm;
				stall = rx_calm ? 0 : $urandom_range(0, STALL_MAX);
				if (stall > 0) begin
					out_ready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			results_seen++;
			if (due_units.size() == 0) begin
				$error("unexpected word: code_unit %h last %b", out_word.code_unit,
					out_word.last);
				errors++;
			end else begin
				want = due_units.pop_front();
				if (out_word.code_unit !== want.code_unit) begin
					$error("code_unit: expected %h, got %h", want.code_unit,
						out_word.code_unit);
					errors++;
				end
				if (out_word.last !== want.last) begin
					$error("last: expected %b, got %b", want.last, out_word.last);
					errors++;
				end
			end
		end
	end

	initial begin : watchdog
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle = 0;
			else
				idle++;
		end
		$display("DONE: errors detected");
		$finish;
	end

endmodule
